FILE: design/mbd_pkg.sv
// shared types and constants of the multi-button debouncer
// no dependencies

package mbd_pkg;

	localparam int BUTTON_COUNT = 9;
	localparam int PIN_W        = 9;
	localparam int NOW_W        = 32;
	localparam int DELAY_W      = 16;
	localparam int IDX_W        = 4;
	localparam int S_TDATA_W    = 48;
	localparam int M_TDATA_W    = 8;
	localparam int PADDR_W      = 1;
	localparam int PDATA_W      = 32;

	localparam logic [PADDR_W-1:0] REG_DEBOUNCE_MS = 1'b0;
	localparam logic [DELAY_W-1:0] DEBOUNCE_RESET  = 16'd50;

	// one pending event held in a cell
	typedef struct packed {
		logic             ev;
		logic [IDX_W-1:0] idx;
		logic             pressed;
	} evt_rec_t;

endpackage

FILE: design/multi_button_debouncer_unit.sv
// top level of the multi-button debouncer: cell chain, event output register, apb register
// depends on mbd_pkg and mbd_cell
//
// usage:
//   s_* stream: one beat is one poll, tdata = {now_ms, pin_levels} (pin_levels low).
//   m_* stream: one beat per debounced state change, tdata = {pad, pressed, button_index},
//   tlast marks the final event of a poll. a poll with no change gives no beat.
//   apb port: register 0 at byte address 0 is debounce_ms (16 bits, reset 50).
// timing:
//   a poll is taken with all cells updating together. events then shift one
//   cell per cycle toward cell 0 while no stall holds cell 0, and leave through the output
//   register; s_tready stays low while any cell still holds an event.
// stall:
//   when m_tready is low the held beat stays and the chain stops once an event reaches
//   cell 0; the last event can wait in the output register while the next poll is taken.
// reset:
//   all buttons released, stable-since times zero, no pending events, debounce_ms 50.

module multi_button_debouncer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// fields from bit 0: pin_levels[8:0], now_ms[40:9], zero pad
	input  logic [mbd_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// fields from bit 0: button_index[3:0], pressed[4], zero pad
	output logic [mbd_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbd_pkg::PADDR_W-1:0]   paddr,
	input  logic [mbd_pkg::PDATA_W-1:0]   pwdata,
	output logic [mbd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int N = mbd_pkg::BUTTON_COUNT;

	logic [mbd_pkg::DELAY_W-1:0] debounce_q;
	logic [mbd_pkg::PIN_W-1:0]   pins;
	logic [mbd_pkg::NOW_W-1:0]   now_ms;
	logic                        load;
	logic                        advance;
	logic [N-1:0]                ev_vec;
	logic [N-1:0]                rest_ev;
	mbd_pkg::evt_rec_t           rec [N+1];
	mbd_pkg::evt_rec_t           head;

	logic                        m_tvalid_q;
	logic [mbd_pkg::IDX_W-1:0]   idx_q;
	logic                        pressed_q;
	logic                        last_q;

	// apb register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= mbd_pkg::DEBOUNCE_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr == mbd_pkg::REG_DEBOUNCE_MS) begin
			debounce_q <= pwdata[mbd_pkg::DELAY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == mbd_pkg::REG_DEBOUNCE_MS) begin
			prdata = {{(mbd_pkg::PDATA_W-mbd_pkg::DELAY_W){1'b0}}, debounce_q};
		end
	end

	// poll input
	assign pins     = s_tdata[mbd_pkg::PIN_W-1:0];
	assign now_ms   = s_tdata[mbd_pkg::PIN_W +: mbd_pkg::NOW_W];
	assign s_tready = ~|ev_vec;
	assign load     = s_tvalid && s_tready;

	// cell chain
	assign head    = rec[0];
	assign advance = !(head.ev && m_tvalid_q && !m_tready);
	assign rest_ev = ev_vec >> 1;
	assign rec[N]  = '0;

	for (genvar k = 0; k < N; k++) begin : g_cell
		logic sample;
		if (k < mbd_pkg::PIN_W) begin : g_pin
			assign sample = ~pins[k];
		end else begin : g_nopin
			assign sample = 1'b1;
		end

		mbd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.load        (load),
			.shift       (advance),
			.sample      (sample),
			.now_ms      (now_ms),
			.debounce_ms (debounce_q),
			.cell_idx    (mbd_pkg::IDX_W'(k)),
			.rec_in      (rec[k+1]),
			.rec_out     (rec[k])
		);

		assign ev_vec[k] = rec[k].ev;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && head.ev) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head.ev) begin
			idx_q     <= head.idx;
			pressed_q <= head.pressed;
			last_q    <= ~|rest_ev;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(mbd_pkg::M_TDATA_W-mbd_pkg::IDX_W-1){1'b0}}, pressed_q, idx_q};

endmodule

FILE: design/mbd_cell.sv
// one button cell of the debouncer chain: debounce state and event record slot
// depends on mbd_pkg

module mbd_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        shift,
	input  logic                        sample,
	input  logic [mbd_pkg::NOW_W-1:0]   now_ms,
	input  logic [mbd_pkg::DELAY_W-1:0] debounce_ms,
	input  logic [mbd_pkg::IDX_W-1:0]   cell_idx,
	input  mbd_pkg::evt_rec_t           rec_in,
	output mbd_pkg::evt_rec_t           rec_out
);

	logic [mbd_pkg::NOW_W-1:0] stable_q;
	logic                      deb_q;
	logic                      prev_q;
	logic                      ev_q;
	logic [mbd_pkg::IDX_W-1:0] idx_q;
	logic                      pr_q;

	logic                      chg;
	logic [mbd_pkg::NOW_W-1:0] since_n;
	logic [mbd_pkg::NOW_W-1:0] elapsed;
	logic                      fire;

	assign chg     = sample != prev_q;
	assign since_n = chg ? now_ms : stable_q;
	assign elapsed = now_ms - since_n;
	assign fire    = (elapsed > {{(mbd_pkg::NOW_W-mbd_pkg::DELAY_W){1'b0}}, debounce_ms})
		&& (sample != deb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			deb_q    <= 1'b0;
			prev_q   <= 1'b0;
			ev_q     <= 1'b0;
		end else if (load) begin
			stable_q <= since_n;
			prev_q   <= sample;
			ev_q     <= fire;
			if (fire) begin
				deb_q <= sample;
			end
		end else if (shift) begin
			ev_q <= rec_in.ev;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q <= cell_idx;
			pr_q  <= sample;
		end else if (shift) begin
			idx_q <= rec_in.idx;
			pr_q  <= rec_in.pressed;
		end
	end

	assign rec_out.ev      = ev_q;
	assign rec_out.idx     = idx_q;
	assign rec_out.pressed = pr_q;

endmodule

FILE: design/mbd_checker.sv
// port-level checks of the multi-button debouncer, bound to the top level
// depends on mbd_pkg and multi_button_debouncer_unit

module mbd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic [mbd_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready
);

	// a stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output beat changed");

	// button index stays within the button count
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[mbd_pkg::IDX_W-1:0] < mbd_pkg::IDX_W'(mbd_pkg::BUTTON_COUNT))
		else $error("button index out of range");

	// pad bits of the event beat are zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[mbd_pkg::M_TDATA_W-1:mbd_pkg::IDX_W+1] == '0)
		else $error("nonzero pad in event beat");

	// more events of the poll are pending, so no new poll is taken
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |-> !s_tready)
		else $error("poll accepted inside an event run");

endmodule

bind multi_button_debouncer_unit mbd_checker u_mbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

FILE: bench/tb_multi_button_debouncer_unit.sv
// testbench of multi_button_debouncer_unit: polls in on the s_ stream, events out on the m_ stream
// a scoreboard class tracks the per-button debounce state and checks every event beat
// depends on mbd_pkg and the design files

module tb_multi_button_debouncer_unit;
	import mbd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam logic [PADDR_W-1:0] REG_UNUSED = ~REG_DEBOUNCE_MS;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic             pressed;
		logic             last;
	} button_event_t;

	class debounce_tracker;
		logic [DELAY_W-1:0] delay_ms;
		logic [NOW_W-1:0]   since_ms [BUTTON_COUNT];
		logic               held [BUTTON_COUNT];
		logic               last_level [BUTTON_COUNT];
		button_event_t      pending_events [$];
		int                 errors;

		function new();
			delay_ms = DEBOUNCE_RESET;
			errors = 0;
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				since_ms[b] = '0;
				held[b] = 1'b0;
				last_level[b] = 1'b0;
			end
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void take_poll(logic [PIN_W-1:0] pins, logic [NOW_W-1:0] now);
			logic [BUTTON_COUNT-1:0] fired;
			logic                    sample;
			button_event_t           ev;
			fired = '0;
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				sample = ~pins[b];
				if (sample != last_level[b])
					since_ms[b] = now;
				if ((now - since_ms[b]) > {16'b0, delay_ms} && sample != held[b]) begin
					held[b] = sample;
					fired[b] = 1'b1;
				end
				last_level[b] = sample;
			end
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				if (fired[b]) begin
					ev.idx = IDX_W'(b);
					ev.pressed = held[b];
					ev.last = ((fired >> (b + 1)) == '0);
					pending_events.push_back(ev);
				end
			end
		endfunction

		function void check_event(logic [M_TDATA_W-1:0] data, logic last);
			button_event_t want;
			if (pending_events.size() == 0) begin
				note_error($sformatf("unexpected event: idx %0d pressed %0b last %0b",
					data[IDX_W-1:0], data[IDX_W], last));
				return;
			end
			want = pending_events.pop_front();
			if (data[IDX_W-1:0] !== want.idx || data[IDX_W] !== want.pressed
					|| last !== want.last)
				note_error($sformatf("event mismatch: expected idx %0d pressed %0b last %0b, got idx %0d pressed %0b last %0b",
					want.idx, want.pressed, want.last, data[IDX_W-1:0], data[IDX_W], last));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	debounce_tracker tracker = new();
	bit              quiet = 1'b0;
	int              ready_hold = 0;
	int unsigned     cycles = 0;
	logic [NOW_W-1:0] poll_ms;
	logic [PIN_W-1:0] pin_state;

	multi_button_debouncer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// polls are noted before events so a beat pair on one edge stays ordered
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.take_poll(s_tdata[PIN_W-1:0], s_tdata[PIN_W +: NOW_W]);
			if (m_tvalid && m_tready)
				tracker.check_event(m_tdata, m_tlast);
		end
	end

	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 0;
		else if (r < 9)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 40);
	endfunction

	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (quiet || $urandom_range(0, 2) != 0) begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b0;
			ready_hold <= gap_len();
		end
	end

	task automatic send_poll(input logic [PIN_W-1:0] pins, input logic [NOW_W-1:0] now);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({now, pins});
		do @(posedge clk); while (!s_tready);
	endtask

	// stop the poll stream, wait until every expected event has been checked, then idle before returning
	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_events.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= write;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_delay_reg();
		logic [PDATA_W-1:0] rdata;
		apb_access(1'b0, REG_DEBOUNCE_MS, '0, rdata);
		if (rdata !== {16'b0, tracker.delay_ms})
			tracker.note_error($sformatf("debounce_ms read: expected %0d, got %0d",
				tracker.delay_ms, rdata));
	endtask

	task automatic set_delay(input logic [DELAY_W-1:0] value);
		logic [PDATA_W-1:0] rdata;
		drain_events();
		apb_access(1'b1, REG_DEBOUNCE_MS, {16'($urandom), value}, rdata);
		tracker.delay_ms = value;
		check_delay_reg();
	endtask

	task automatic run_phase(input int polls);
		logic [PIN_W-1:0] flips;
		logic [NOW_W-1:0] step;
		int r;
		for (int i = 0; i < polls; i++) begin
			r = $urandom_range(0, 19);
			if (r < 12) begin
				flips = '0;
				for (int b = 0; b < PIN_W; b++)
					flips[b] = ($urandom_range(0, 5) == 0);
				pin_state = pin_state ^ flips;
			end else if (r < 15) begin
				pin_state = PIN_W'($urandom);
			end
			r = $urandom_range(0, 9);
			if (r < 3)
				step = $urandom_range(0, 3);
			else if (r < 5)
				step = {16'b0, tracker.delay_ms} + $urandom_range(0, 4) - 2;
			else if (r < 9)
				step = {16'b0, tracker.delay_ms} + $urandom_range(1, 100);
			else
				step = $urandom;
			poll_ms = poll_ms + step;
			send_poll(pin_state, poll_ms);
		end
	endtask

	initial begin
		logic [PDATA_W-1:0] rdata;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_delay_reg();

		// reset delay: all press, all release, backwards step, wrap of the timestamp
		send_poll(9'h000, 32'd10);
		send_poll(9'h000, 32'd60);
		send_poll(9'h000, 32'd61);
		send_poll(9'h1FF, 32'd62);
		send_poll(9'h1FF, 32'd113);
		send_poll(9'h1FE, 32'd200);
		send_poll(9'h1FE, 32'd100);
		send_poll(9'h1FF, 32'hFFFF_FFF0);
		send_poll(9'h1FF, 32'h0000_0030);
		send_poll(9'h0AA, 32'h0000_0040);
		send_poll(9'h0AA, 32'h0000_0073);

		// zero delay: a fresh change waits for a later poll
		set_delay(16'd0);
		send_poll(9'h1FF, 32'h0000_0100);
		send_poll(9'h1FF, 32'h0000_0100);
		send_poll(9'h1FF, 32'h0000_0101);
		send_poll(9'h0FF, 32'h0000_0101);
		send_poll(9'h0FF, 32'h0000_0102);

		// widest delay, and a write to an unmapped address that must not land
		set_delay(16'hFFFF);
		apb_access(1'b1, REG_UNUSED, 32'h0000_0007, rdata);
		check_delay_reg();
		send_poll(9'h1FF, 32'h0000_1000);
		send_poll(9'h1FF, 32'h0001_0FFF);
		send_poll(9'h1FF, 32'h0001_1000);
		send_poll(9'h000, 32'hFFFF_FFFF);
		send_poll(9'h000, 32'h0000_FFFF);

		poll_ms = 32'h0000_FFFF;
		pin_state = 9'h000;
		set_delay(16'd1);
		run_phase(55);
		set_delay(16'd0);
		quiet = 1'b1;
		run_phase(55);
		quiet = 1'b0;
		set_delay(DELAY_W'($urandom_range(2, 300)));
		run_phase(60);
		set_delay(16'hFFFF);
		run_phase(50);
		set_delay(DELAY_W'($urandom));
		run_phase(60);
		set_delay(DEBOUNCE_RESET);
		run_phase(60);

		drain_events();
		if (tracker.errors == 0 && tracker.pending_events.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
